FILE: hw/rtl/rfd_pkg.sv
// Shared types and constants for the RPC frame deframer.
// Holds the phase encoding, result kinds, status codes and register indexes.
// No dependencies.
package rfd_pkg;

  // Framing bytes and fixed frame overhead
  localparam logic [7:0]  START_BYTE     = 8'h02;
  localparam logic [7:0]  END_BYTE       = 8'h03;
  localparam logic [15:0] FIXED_OVERHEAD = 16'd26;
  localparam logic [15:0] NUM_BYTES      = 16'd4;

  // Register reset values
  localparam logic [15:0] MAX_PACKET_LEN_RST = 16'd65535;
  localparam logic [7:0]  MAX_ID_LEN_RST     = 8'd49;
  localparam logic [11:0] MAX_SN_LEN_RST     = 12'd511;
  localparam logic [11:0] MAX_EI_LEN_RST     = 12'd511;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_MAX_PACKET_LEN = 2'd0;
  localparam logic [1:0] REG_MAX_ID_LEN     = 2'd1;
  localparam logic [1:0] REG_MAX_SN_LEN     = 2'd2;
  localparam logic [1:0] REG_MAX_EI_LEN     = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_STATUS  = 3'd0;
  localparam logic [2:0] KIND_ID      = 3'd1;
  localparam logic [2:0] KIND_SN      = 3'd2;
  localparam logic [2:0] KIND_EI      = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;

  // Frame status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_END      = 3'd1;
  localparam logic [2:0] ST_EMPTY_ID     = 3'd2;
  localparam logic [2:0] ST_OVER_LIMIT   = 3'd3;
  localparam logic [2:0] ST_INCONSISTENT = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [11:0] {
    PH_HUNT    = 12'b0000_0000_0001,
    PH_PKLEN   = 12'b0000_0000_0010,
    PH_IDLEN   = 12'b0000_0000_0100,
    PH_ID      = 12'b0000_0000_1000,
    PH_SNLEN   = 12'b0000_0001_0000,
    PH_SN      = 12'b0000_0010_0000,
    PH_ECODE   = 12'b0000_0100_0000,
    PH_EILEN   = 12'b0000_1000_0000,
    PH_EI      = 12'b0001_0000_0000,
    PH_PAYLOAD = 12'b0010_0000_0000,
    PH_CKSUM   = 12'b0100_0000_0000,
    PH_END     = 12'b1000_0000_0000
  } phase_t;

endpackage

FILE: hw/rtl/rpc_frame_deframer_unit.sv
// RPC frame deframer top level: byte-stream parser and APB register block.
// Depends on rfd_pkg.
//
// Takes one received byte per clock cycle, sustained while in_ready is high,
// with no gaps between frames. Each accepted byte advances the parser state in
// the same cycle and any result it causes (a tagged field byte or a closing
// status) appears in the output register in the next cycle. in_ready is low
// only while a result sits unclaimed in the output register. Frame start is
// 0x02; the header numbers are 32-bit big-endian; the checksum is skipped;
// 0x03 closes the frame. Every frame attempt ends with exactly one status beat
// (frame_last high) carrying the frame's error code and packet length. Limits
// are set through four APB registers at byte addresses 0, 4, 8 and 12 and
// should only be written while the stream is idle.
module rpc_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  field_kind,
  output logic [7:0]  data_byte,
  output logic        frame_last,
  output logic [2:0]  frame_status,
  output logic signed [31:0] error_code,
  output logic [15:0] packet_length,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfd_pkg::*;

  // configuration registers
  logic [15:0] max_packet_len;
  logic [7:0]  max_request_id_len;
  logic [11:0] max_service_name_len;
  logic [11:0] max_error_text_len;

  // parser state
  phase_t      phase, phase_next;
  logic [15:0] field_remaining, field_remaining_next;
  logic [31:0] header_shift, header_shift_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_accounted, bytes_accounted_next;
  logic [31:0] carried_error_code, carried_error_code_next;

  // result of the current byte
  logic        res_valid;
  logic [2:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [2:0]  res_status;
  logic [31:0] res_ecode;
  logic [15:0] res_plen;

  logic        in_fire;
  logic [31:0] shift_word;
  logic [15:0] rem_dec;
  logic [31:0] len_limit;
  logic        len_over;
  logic [16:0] acc_sum;
  logic        len_inconsistent;
  logic [15:0] pay_rem;
  logic        cfg_wr;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len       <= MAX_PACKET_LEN_RST;
      max_request_id_len   <= MAX_ID_LEN_RST;
      max_service_name_len <= MAX_SN_LEN_RST;
      max_error_text_len   <= MAX_EI_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_PACKET_LEN: max_packet_len       <= pwdata[15:0];
        REG_MAX_ID_LEN:     max_request_id_len   <= pwdata[7:0];
        REG_MAX_SN_LEN:     max_service_name_len <= pwdata[11:0];
        REG_MAX_EI_LEN:     max_error_text_len   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_MAX_PACKET_LEN: prdata = {16'd0, max_packet_len};
      REG_MAX_ID_LEN:     prdata = {24'd0, max_request_id_len};
      REG_MAX_SN_LEN:     prdata = {20'd0, max_service_name_len};
      REG_MAX_EI_LEN:     prdata = {20'd0, max_error_text_len};
      default:            prdata = 32'd0;
    endcase
  end

  // shared header arithmetic
  assign shift_word = {header_shift[23:0], rx_byte};
  assign rem_dec    = field_remaining - 16'd1;
  assign pay_rem    = frame_length - bytes_accounted;

  // pick the limit for the length field being closed
  always_comb begin
    case (phase)
      PH_IDLEN: len_limit = {24'd0, max_request_id_len};
      PH_SNLEN: len_limit = {20'd0, max_service_name_len};
      default:  len_limit = {20'd0, max_error_text_len};
    endcase
  end

  // the low half of the length is only used once it passed the limit check
  assign len_over         = shift_word > len_limit;
  assign acc_sum          = {1'b0, bytes_accounted} + {1'b0, shift_word[15:0]};
  assign len_inconsistent = acc_sum > {1'b0, frame_length};

  // next state and result for one accepted byte
  always_comb begin
    phase_next              = phase;
    field_remaining_next    = field_remaining;
    header_shift_next       = header_shift;
    frame_length_next       = frame_length;
    bytes_accounted_next    = bytes_accounted;
    carried_error_code_next = carried_error_code;
    res_valid  = 1'b0;
    res_kind   = KIND_STATUS;
    res_byte   = 8'd0;
    res_last   = 1'b0;
    res_status = ST_OK;
    res_ecode  = 32'd0;
    res_plen   = 16'd0;

    case (phase)
      PH_PKLEN, PH_IDLEN, PH_SNLEN, PH_ECODE, PH_EILEN: begin
        header_shift_next    = shift_word;
        field_remaining_next = rem_dec;
        if (rem_dec == 16'd0) begin
          header_shift_next = 32'd0;
          case (phase)
            PH_PKLEN: begin
              if (shift_word > {16'd0, max_packet_len}) begin
                res_valid  = 1'b1;
                res_status = ST_OVER_LIMIT;
                res_plen   = (shift_word[31:16] != 16'd0) ? 16'hFFFF : shift_word[15:0];
              end else begin
                frame_length_next = shift_word[15:0];
                if (shift_word[15:0] < FIXED_OVERHEAD) begin
                  res_valid  = 1'b1;
                  res_status = ST_INCONSISTENT;
                  res_plen   = shift_word[15:0];
                end else begin
                  phase_next           = PH_IDLEN;
                  field_remaining_next = NUM_BYTES;
                end
              end
            end
            PH_ECODE: begin
              carried_error_code_next = shift_word;
              phase_next              = PH_EILEN;
              field_remaining_next    = NUM_BYTES;
            end
            default: begin
              // a length field: empty id, limit, then consistency
              res_plen = frame_length;
              if (phase == PH_IDLEN && shift_word == 32'd0) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY_ID;
              end else if (len_over) begin
                res_valid  = 1'b1;
                res_status = ST_OVER_LIMIT;
              end else if (len_inconsistent) begin
                res_valid  = 1'b1;
                res_status = ST_INCONSISTENT;
              end else begin
                bytes_accounted_next = acc_sum[15:0];
                field_remaining_next = shift_word[15:0];
                case (phase)
                  PH_IDLEN: phase_next = PH_ID;
                  PH_SNLEN: begin
                    if (shift_word == 32'd0) begin
                      phase_next           = PH_ECODE;
                      field_remaining_next = NUM_BYTES;
                    end else begin
                      phase_next = PH_SN;
                    end
                  end
                  default: begin
                    if (shift_word != 32'd0) begin
                      phase_next = PH_EI;
                    end else if (pay_rem == 16'd0) begin
                      phase_next           = PH_CKSUM;
                      field_remaining_next = NUM_BYTES;
                    end else begin
                      phase_next           = PH_PAYLOAD;
                      field_remaining_next = pay_rem;
                    end
                  end
                endcase
              end
            end
          endcase
          if (res_valid) begin
            res_last             = 1'b1;
            res_ecode            = carried_error_code;
            phase_next           = PH_HUNT;
            field_remaining_next = 16'd0;
          end
        end
      end
      PH_ID, PH_SN, PH_EI, PH_PAYLOAD: begin
        // emit the field byte and advance at the end of the field
        res_valid            = 1'b1;
        res_byte             = rx_byte;
        field_remaining_next = rem_dec;
        case (phase)
          PH_ID:   res_kind = KIND_ID;
          PH_SN:   res_kind = KIND_SN;
          PH_EI:   res_kind = KIND_EI;
          default: res_kind = KIND_PAYLOAD;
        endcase
        if (rem_dec == 16'd0) begin
          header_shift_next    = 32'd0;
          field_remaining_next = NUM_BYTES;
          case (phase)
            PH_ID: phase_next = PH_SNLEN;
            PH_SN: phase_next = PH_ECODE;
            PH_EI: begin
              if (pay_rem == 16'd0) begin
                phase_next = PH_CKSUM;
              end else begin
                phase_next           = PH_PAYLOAD;
                field_remaining_next = pay_rem;
              end
            end
            default: phase_next = PH_CKSUM;
          endcase
        end
      end
      PH_CKSUM: begin
        // skip the checksum
        field_remaining_next = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        res_valid            = 1'b1;
        res_last             = 1'b1;
        res_status           = (rx_byte == END_BYTE) ? ST_OK : ST_BAD_END;
        res_ecode            = carried_error_code;
        res_plen             = frame_length;
        phase_next           = PH_HUNT;
        field_remaining_next = 16'd0;
        header_shift_next    = 32'd0;
      end
      default: begin
        // hunt: drop everything but the start byte
        phase_next = PH_HUNT;
        if (rx_byte == START_BYTE) begin
          phase_next              = PH_PKLEN;
          field_remaining_next    = NUM_BYTES;
          header_shift_next       = 32'd0;
          frame_length_next       = 16'd0;
          bytes_accounted_next    = FIXED_OVERHEAD;
          carried_error_code_next = 32'd0;
        end
      end
    endcase
  end

  // parser state update on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      field_remaining    <= 16'd0;
      header_shift       <= 32'd0;
      frame_length       <= 16'd0;
      bytes_accounted    <= 16'd0;
      carried_error_code <= 32'd0;
    end else if (in_fire) begin
      phase              <= phase_next;
      field_remaining    <= field_remaining_next;
      header_shift       <= header_shift_next;
      frame_length       <= frame_length_next;
      bytes_accounted    <= bytes_accounted_next;
      carried_error_code <= carried_error_code_next;
    end
  end

  // output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      field_kind    <= res_kind;
      data_byte     <= res_byte;
      frame_last    <= res_last;
      frame_status  <= res_status;
      error_code    <= res_ecode;
      packet_length <= res_plen;
    end
  end

  // a closing beat always carries the status kind
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> field_kind == KIND_STATUS)
    else $error("frame_last on a data beat");

  // any result from a header or end byte returns the parser to hunting
  a_status_hunts: assert property (@(posedge clk) disable iff (rst)
    in_fire && res_valid && res_last |=> phase == PH_HUNT)
    else $error("parser did not resume hunting after a status");

  // a data field phase always has bytes left to take
  a_field_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID || phase == PH_SN || phase == PH_EI || phase == PH_PAYLOAD)
      |-> field_remaining != 16'd0)
    else $error("data phase entered with zero length");

  // accounted length never exceeds the frame length once a field is taken
  a_accounting: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID || phase == PH_SN || phase == PH_EI || phase == PH_PAYLOAD ||
     phase == PH_CKSUM || phase == PH_END) |-> bytes_accounted <= frame_length)
    else $error("accounted bytes exceed frame length");

endmodule
